// ===== src/plri_pkg.sv =====
package plri_pkg;

    localparam int DEFAULT_MAX_POINTS = 16;
    localparam int DIV_STEPS = 64;

    typedef logic signed [63:0] q_t;

    localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

    localparam logic [3:0] CFG_NUM_POINTS = 4'd0;
    localparam logic [3:0] CFG_EXTRAPOLATE = 4'd1;

    typedef enum logic {
        CMD_EVAL = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_WITHIN = 2'd0,
        ST_BELOW  = 2'd1,
        ST_ABOVE  = 2'd2,
        ST_LOAD   = 2'd3
    } status_t;

    typedef struct packed {
        q_t log_pressure;
        q_t log_prefactor;
        q_t temp_exponent;
        q_t activation_temp;
    } coef_t;

    typedef struct packed {
        q_t inv_t;
        q_t log_t;
        q_t lp;
    } eval_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] range_used;
        logic       hold;
    } front_info_t;

    function automatic q_t add_sat(input q_t a, input q_t b);
        q_t s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? Q_MIN : Q_MAX;
        return s;
    endfunction

    function automatic q_t sub_sat(input q_t a, input q_t b);
        q_t s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
            return a[63] ? Q_MIN : Q_MAX;
        return s;
    endfunction

    function automatic logic [63:0] mag(input q_t x);
        logic [63:0] u;
        u = x;
        return x[63] ? (~u + 64'd1) : u;
    endfunction

    // Signed value from a sign and a magnitude, saturated to 64 bits.
    function automatic q_t from_mag(input logic neg, input logic hi_nz, input logic [63:0] m);
        q_t v;
        v = m;
        if (hi_nz || m[63])
            return neg ? Q_MIN : Q_MAX;
        return neg ? -v : v;
    endfunction

endpackage

// ===== src/plri_umul.sv =====
module plri_umul #(
    parameter int LANES = 1,
    parameter int SIDE_W = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     v_in,
    input  logic [LANES-1:0][63:0]   a_in,
    input  logic [LANES-1:0][63:0]   b_in,
    input  logic [SIDE_W-1:0]        side_in,
    output logic                     v_out,
    output logic [LANES-1:0][127:0]  prod,
    output logic [SIDE_W-1:0]        side_out
);

    // Four 32x32 partial products per lane, summed in the second stage.
    logic [LANES-1:0][3:0][63:0] pp_reg;
    logic [LANES-1:0][127:0]     prod_reg;
    logic [SIDE_W-1:0]           side1_reg;
    logic [SIDE_W-1:0]           side2_reg;
    logic                        v1_reg;
    logic                        v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                pp_reg[l][0] <= {32'd0, a_in[l][31:0]} * {32'd0, b_in[l][31:0]};
                pp_reg[l][1] <= {32'd0, a_in[l][31:0]} * {32'd0, b_in[l][63:32]};
                pp_reg[l][2] <= {32'd0, a_in[l][63:32]} * {32'd0, b_in[l][31:0]};
                pp_reg[l][3] <= {32'd0, a_in[l][63:32]} * {32'd0, b_in[l][63:32]};
                prod_reg[l] <= {pp_reg[l][3], 64'd0}
                             + {32'd0, pp_reg[l][1], 32'd0}
                             + {32'd0, pp_reg[l][2], 32'd0}
                             + {64'd0, pp_reg[l][0]};
            end
            side1_reg <= side_in;
            side2_reg <= side1_reg;
        end
    end

    assign v_out = v2_reg;
    assign prod = prod_reg;
    assign side_out = side2_reg;

endmodule

// ===== src/plri_div.sv =====
module plri_div
    import plri_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              v_in,
    input  logic [63:0]       hi,
    input  logic [63:0]       lo,
    input  logic [63:0]       d,
    input  logic              zero,
    input  logic              sat,
    input  logic              neg,
    input  logic [SIDE_W-1:0] side_in,
    output logic              v_out,
    output q_t                quot,
    output logic [SIDE_W-1:0] side_out
);

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] q;
        logic [63:0] d;
        logic        zero;
        logic        sat;
        logic        neg;
    } dstage_t;

    dstage_t           st_reg [DIV_STEPS+1];
    logic [SIDE_W-1:0] side_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0] v_reg;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic dstage_t div_step(input dstage_t s);
        dstage_t     r;
        logic [64:0] t;
        logic [64:0] dd;
        r = s;
        t = {s.rem, s.lo[63]};
        dd = {1'b0, s.d};
        r.lo = {s.lo[62:0], 1'b0};
        if (t >= dd)
        begin
            t = t - dd;
            r.q = {s.q[62:0], 1'b1};
        end
        else
        begin
            r.q = {s.q[62:0], 1'b0};
        end
        r.rem = t[63:0];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[DIV_STEPS-1:0], v_in};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= '{rem: hi, lo: lo, q: 64'd0, d: d, zero: zero, sat: sat, neg: neg};
            side_reg[0] <= side_in;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                st_reg[i+1] <= div_step(st_reg[i]);
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    always_comb
    begin
        if (st_reg[DIV_STEPS].zero)
            quot = '0;
        else if (st_reg[DIV_STEPS].sat)
            quot = st_reg[DIV_STEPS].neg ? Q_MIN : Q_MAX;
        else
            quot = from_mag(st_reg[DIV_STEPS].neg, 1'b0, st_reg[DIV_STEPS].q);
    end

    assign v_out = v_reg[DIV_STEPS];
    assign side_out = side_reg[DIV_STEPS];

endmodule

// ===== src/plri_front.sv =====
module plri_front
    import plri_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        v_in,
    input  cmd_t        cmd_in,
    input  logic [3:0]  point_index_in,
    input  q_t          ld_pressure,
    input  coef_t       ld_coef,
    input  q_t          p_in,
    input  eval_t       eval_in,
    input  logic [4:0]  num_points,
    input  logic        extrapolate_enable,
    output logic        v_out,
    output front_info_t info_out,
    output coef_t       row_a,
    output coef_t       row_b,
    output eval_t       eval_out
);

    localparam int IW = $clog2(MAX_POINTS);

    q_t    pressure_reg [MAX_POINTS];
    coef_t coef_mem [MAX_POINTS];

    logic [6:0]            pidx_ext;
    logic [6:0]            n_ext;
    logic [6:0]            n_clamp;
    logic [6:0]            last_ext;
    logic                  ld_ok;
    logic [IW-1:0]         ld_addr;
    logic [IW-1:0]         last;
    logic [MAX_POINTS-1:0] ge;

    // Stage 1: compare flags.
    logic                  v1_reg;
    logic                  load1_reg;
    logic [MAX_POINTS-1:0] ge1_reg;
    logic [IW-1:0]         last1_reg;
    logic                  ld_ok1_reg;
    logic [IW-1:0]         ld_addr1_reg;
    coef_t                 ld_coef1_reg;
    eval_t                 eval1_reg;

    // Stage 2: range chosen.
    logic                  v2_reg;
    front_info_t           info2_reg;
    logic [IW-1:0]         a2_reg;
    logic [IW-1:0]         b2_reg;
    logic                  ld_ok2_reg;
    logic [IW-1:0]         ld_addr2_reg;
    coef_t                 ld_coef2_reg;
    eval_t                 eval2_reg;

    // Stage 3: coefficients read.
    logic                  v3_reg;
    front_info_t           info3_reg;
    coef_t                 row_a_reg;
    coef_t                 row_b_reg;
    eval_t                 eval3_reg;

    logic                  below;
    logic                  above;
    logic                  found;
    logic [IW-1:0]         j_srch;
    logic [IW-1:0]         jr;
    logic [6:0]            jr_ext;
    logic [IW-1:0]         a_next;
    logic [IW-1:0]         b_next;
    front_info_t           info_next;

    assign pidx_ext = {3'b000, point_index_in};
    assign ld_ok = pidx_ext < 7'(MAX_POINTS);
    assign ld_addr = pidx_ext[IW-1:0];
    assign n_ext = {2'b00, num_points};

    always_comb
    begin
        if (n_ext < 7'd2)
            n_clamp = 7'd2;
        else if (n_ext > 7'(MAX_POINTS))
            n_clamp = 7'(MAX_POINTS);
        else
            n_clamp = n_ext;
    end

    assign last_ext = n_clamp - 7'd1;
    assign last = last_ext[IW-1:0];

    always_comb
    begin
        for (int k = 0; k < MAX_POINTS; k++)
            ge[k] = p_in >= pressure_reg[k];
    end

    // The pressure table is written when a load leaves stage 0, the same
    // edge at which its own compare flags are taken.
    always_ff @(posedge clk)
    begin
        if (adv && v_in && cmd_in == CMD_LOAD && ld_ok)
            pressure_reg[ld_addr] <= ld_pressure;
    end

    assign below = !ge1_reg[0];
    assign above = ge1_reg[last1_reg];

    always_comb
    begin
        found = 1'b0;
        j_srch = '0;
        for (int k = 0; k < MAX_POINTS - 1; k++)
        begin
            if (!found && IW'(k) < last1_reg && ge1_reg[k] && !ge1_reg[k+1])
            begin
                j_srch = IW'(k);
                found = 1'b1;
            end
        end

        info_next.hold = 1'b0;
        a_next = '0;
        jr = '0;
        if (load1_reg)
        begin
            info_next.status = ST_LOAD;
            info_next.hold = 1'b1;
        end
        else if (!below && !above)
        begin
            info_next.status = ST_WITHIN;
            a_next = j_srch;
            jr = j_srch;
        end
        else if (below)
        begin
            info_next.status = ST_BELOW;
            info_next.hold = !extrapolate_enable;
        end
        else
        begin
            info_next.status = ST_ABOVE;
            if (extrapolate_enable)
                a_next = IW'(last1_reg - 1'b1);
            else
            begin
                a_next = last1_reg;
                info_next.hold = 1'b1;
            end
            jr = a_next;
        end
        jr_ext = {{(7 - IW){1'b0}}, jr};
        info_next.range_used = jr_ext[3:0];
        b_next = (a_next == IW'(MAX_POINTS - 1)) ? a_next : IW'(a_next + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            load1_reg <= cmd_in == CMD_LOAD;
            ge1_reg <= ge;
            last1_reg <= last;
            ld_ok1_reg <= ld_ok;
            ld_addr1_reg <= ld_addr;
            ld_coef1_reg <= ld_coef;
            eval1_reg <= eval_in;

            info2_reg <= info_next;
            a2_reg <= a_next;
            b2_reg <= b_next;
            ld_ok2_reg <= ld_ok1_reg;
            ld_addr2_reg <= ld_addr1_reg;
            ld_coef2_reg <= ld_coef1_reg;
            eval2_reg <= eval1_reg;

            info3_reg <= info2_reg;
            eval3_reg <= eval2_reg;
        end
    end

    // Coefficient memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (v2_reg && info2_reg.status == ST_LOAD && ld_ok2_reg)
                coef_mem[ld_addr2_reg] <= ld_coef2_reg;
            row_a_reg <= coef_mem[a2_reg];
            row_b_reg <= coef_mem[b2_reg];
        end
    end

    assign v_out = v3_reg;
    assign info_out = info3_reg;
    assign row_a = row_a_reg;
    assign row_b = row_b_reg;
    assign eval_out = eval3_reg;

endmodule

// ===== src/plog_rate_interpolator_core.sv =====
// Pressure-dependent Arrhenius log-rate interpolator, signed Q31.32.
// Item channel (item_valid / item_stall): command 1 loads one pressure point
// into slot point_index; command 0 evaluates the log rate at the given
// inverse temperature, log temperature, pressure and log pressure. Points
// must be loaded in ascending pressure order.
// Result channel (result_valid / result_stall): one transaction per item,
// carrying log_rate, range_used and status.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets
// the number of points in use, index 1 enables extrapolation. Write it only
// while no items are in flight.
// Throughput is one item per cycle while result_stall does not freeze the
// pipeline, which holds the 64-step pipelined divider of the interpolation
// term plus a four-lane and a one-lane pipelined 64x64 multiplier.
// When result_stall is high with a result pending, the whole pipeline
// freezes and item_stall rises; nothing is lost or repeated. Reset empties
// the pipeline and restores the registers; the point table is undefined
// until loaded.
module plog_rate_interpolator_core
    import plri_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               command,
    input  logic [3:0]         point_index,
    input  logic signed [63:0] point_pressure,
    input  logic signed [63:0] point_log_pressure,
    input  logic signed [63:0] point_log_prefactor,
    input  logic signed [63:0] point_temp_exponent,
    input  logic signed [63:0] point_activation_temp,
    input  logic signed [63:0] recip_temperature,
    input  logic signed [63:0] log_temperature,
    input  logic signed [63:0] eval_pressure,
    input  logic signed [63:0] eval_log_pressure,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [63:0] log_rate,
    output logic [3:0]         range_used,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    typedef struct packed {
        logic [3:0]  neg;
        q_t          lna_a;
        q_t          lna_b;
        q_t          dlp;
        q_t          span;
        front_info_t info;
    } side1_t;

    typedef struct packed {
        q_t          qna;
        q_t          qtaa;
        q_t          qnb;
        q_t          qtab;
        q_t          lna_a;
        q_t          lna_b;
        q_t          dlp;
        q_t          span;
        front_info_t info;
    } s7_t;

    typedef struct packed {
        q_t          ra;
        q_t          rb;
        q_t          qtaa;
        q_t          qtab;
        q_t          dlp;
        q_t          span;
        front_info_t info;
    } s8_t;

    typedef struct packed {
        q_t          k1;
        q_t          k2;
        q_t          dlp;
        q_t          span;
        front_info_t info;
    } s9_t;

    typedef struct packed {
        q_t          k1;
        q_t          dk;
        q_t          dlp;
        q_t          span;
        front_info_t info;
    } s10_t;

    typedef struct packed {
        logic        neg;
        logic [63:0] d;
        logic        cneg;
        q_t          k1;
        front_info_t info;
    } side2_t;

    typedef struct packed {
        q_t          k1;
        front_info_t info;
    } side3_t;

    logic       adv;
    logic [4:0] num_points_reg;
    logic       extrapolate_reg;

    logic  v0_reg;
    cmd_t  cmd0_reg;
    logic [3:0] pidx0_reg;
    q_t    pressure0_reg;
    coef_t coef0_reg;
    q_t    p0_reg;
    eval_t eval0_reg;

    logic        v3;
    front_info_t info3;
    coef_t       row_a3;
    coef_t       row_b3;
    eval_t       eval3;

    logic              v4_reg;
    logic [3:0][63:0]  ma4_reg;
    logic [3:0][63:0]  mb4_reg;
    side1_t            side4_reg;
    side1_t            side4_next;

    logic              v6;
    logic [3:0][127:0] prod6;
    side1_t            side6;
    q_t                q6 [4];

    logic v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;
    s7_t  s7_reg;
    s8_t  s8_reg;
    s9_t  s9_reg;
    s10_t s10_reg;
    logic [0:0][63:0] ma11_reg;
    logic [0:0][63:0] mb11_reg;
    side2_t side11_reg;

    logic              v13;
    logic [0:0][127:0] prod13;
    side2_t            side13;
    logic              div_zero;
    logic              div_sat;
    logic              div_neg;
    side3_t            side_div_in;

    logic   v_div;
    q_t     quot;
    side3_t side_div;
    q_t     rate_next;

    logic        out_valid_reg;
    q_t          rate_reg;
    logic [3:0]  range_reg;
    status_t     status_reg;

    // The pipeline moves as one unit unless a finished result is held.
    assign adv = !out_valid_reg || !result_stall;
    assign item_stall = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= 5'd2;
            extrapolate_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_NUM_POINTS)
                num_points_reg <= cfg_data[4:0];
            else if (cfg_index == CFG_EXTRAPOLATE)
                extrapolate_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v4_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= item_valid;
            v4_reg <= v3;
            v7_reg <= v6;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            out_valid_reg <= v_div;
        end
    end

    plri_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .adv                (adv),
        .v_in               (v0_reg),
        .cmd_in             (cmd0_reg),
        .point_index_in     (pidx0_reg),
        .ld_pressure        (pressure0_reg),
        .ld_coef            (coef0_reg),
        .p_in               (p0_reg),
        .eval_in            (eval0_reg),
        .num_points         (num_points_reg),
        .extrapolate_enable (extrapolate_reg),
        .v_out              (v3),
        .info_out           (info3),
        .row_a              (row_a3),
        .row_b              (row_b3),
        .eval_out           (eval3)
    );

    always_comb
    begin
        side4_next.neg[0] = row_a3.temp_exponent[63] ^ eval3.log_t[63];
        side4_next.neg[1] = row_a3.activation_temp[63] ^ eval3.inv_t[63];
        side4_next.neg[2] = row_b3.temp_exponent[63] ^ eval3.log_t[63];
        side4_next.neg[3] = row_b3.activation_temp[63] ^ eval3.inv_t[63];
        side4_next.lna_a = row_a3.log_prefactor;
        side4_next.lna_b = row_b3.log_prefactor;
        side4_next.dlp = sub_sat(eval3.lp, row_a3.log_pressure);
        side4_next.span = sub_sat(row_b3.log_pressure, row_a3.log_pressure);
        side4_next.info = info3;
    end

    always_comb
    begin
        for (int l = 0; l < 4; l++)
            q6[l] = from_mag(side6.neg[l], |prod6[l][127:96], prod6[l][95:32]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd0_reg <= cmd_t'(command);
            pidx0_reg <= point_index;
            pressure0_reg <= point_pressure;
            coef0_reg <= '{log_pressure: point_log_pressure,
                           log_prefactor: point_log_prefactor,
                           temp_exponent: point_temp_exponent,
                           activation_temp: point_activation_temp};
            p0_reg <= eval_pressure;
            eval0_reg <= '{inv_t: recip_temperature, log_t: log_temperature,
                           lp: eval_log_pressure};

            ma4_reg[0] <= mag(row_a3.temp_exponent);
            mb4_reg[0] <= mag(eval3.log_t);
            ma4_reg[1] <= mag(row_a3.activation_temp);
            mb4_reg[1] <= mag(eval3.inv_t);
            ma4_reg[2] <= mag(row_b3.temp_exponent);
            mb4_reg[2] <= mag(eval3.log_t);
            ma4_reg[3] <= mag(row_b3.activation_temp);
            mb4_reg[3] <= mag(eval3.inv_t);
            side4_reg <= side4_next;

            s7_reg <= '{qna: q6[0], qtaa: q6[1], qnb: q6[2], qtab: q6[3],
                        lna_a: side6.lna_a, lna_b: side6.lna_b,
                        dlp: side6.dlp, span: side6.span, info: side6.info};

            s8_reg <= '{ra: add_sat(s7_reg.lna_a, s7_reg.qna),
                        rb: add_sat(s7_reg.lna_b, s7_reg.qnb),
                        qtaa: s7_reg.qtaa, qtab: s7_reg.qtab,
                        dlp: s7_reg.dlp, span: s7_reg.span, info: s7_reg.info};

            s9_reg <= '{k1: sub_sat(s8_reg.ra, s8_reg.qtaa),
                        k2: sub_sat(s8_reg.rb, s8_reg.qtab),
                        dlp: s8_reg.dlp, span: s8_reg.span, info: s8_reg.info};

            s10_reg <= '{k1: s9_reg.k1, dk: sub_sat(s9_reg.k2, s9_reg.k1),
                         dlp: s9_reg.dlp, span: s9_reg.span, info: s9_reg.info};

            ma11_reg[0] <= mag(s10_reg.dk);
            mb11_reg[0] <= mag(s10_reg.dlp);
            side11_reg <= '{neg: s10_reg.dk[63] ^ s10_reg.dlp[63],
                            d: mag(s10_reg.span), cneg: s10_reg.span[63],
                            k1: s10_reg.k1, info: s10_reg.info};

            rate_reg <= rate_next;
            range_reg <= side_div.info.range_used;
            status_reg <= side_div.info.status;
        end
    end

    plri_umul #(
        .LANES  (4),
        .SIDE_W ($bits(side1_t))
    ) u_mul_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .v_in     (v4_reg),
        .a_in     (ma4_reg),
        .b_in     (mb4_reg),
        .side_in  (side4_reg),
        .v_out    (v6),
        .prod     (prod6),
        .side_out (side6)
    );

    plri_umul #(
        .LANES  (1),
        .SIDE_W ($bits(side2_t))
    ) u_mul_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .v_in     (v11_reg),
        .a_in     (ma11_reg),
        .b_in     (mb11_reg),
        .side_in  (side11_reg),
        .v_out    (v13),
        .prod     (prod13),
        .side_out (side13)
    );

    // A zero span with a nonzero numerator saturates by its sign alone;
    // otherwise a high half at or above the divisor means overflow.
    assign div_zero = prod13[0] == 128'd0;
    assign div_sat = side13.d == 64'd0 || prod13[0][127:64] >= side13.d;
    assign div_neg = (side13.d == 64'd0) ? side13.neg : (side13.neg ^ side13.cneg);
    assign side_div_in = '{k1: side13.k1, info: side13.info};

    plri_div #(
        .SIDE_W ($bits(side3_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .v_in     (v13),
        .hi       (prod13[0][127:64]),
        .lo       (prod13[0][63:0]),
        .d        (side13.d),
        .zero     (div_zero),
        .sat      (div_sat),
        .neg      (div_neg),
        .side_in  (side_div_in),
        .v_out    (v_div),
        .quot     (quot),
        .side_out (side_div)
    );

    always_comb
    begin
        if (side_div.info.status == ST_LOAD)
            rate_next = '0;
        else if (side_div.info.hold)
            rate_next = side_div.k1;
        else
            rate_next = add_sat(side_div.k1, quot);
    end

    assign result_valid = out_valid_reg;
    assign log_rate = rate_reg;
    assign range_used = range_reg;
    assign status = status_reg;

endmodule
